@@ hw/rtl/sow_pkg.sv @@
`default_nettype none

package sow_pkg;

  localparam int CMD_W    = 2;
  localparam int TSEG_W   = 4;
  localparam int AMT_W    = 32;
  localparam int SEG_W    = 5;
  localparam int RIDX_W   = 32;
  localparam int DIST_W   = 36;
  localparam int CFG_W    = 5;
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 80;

  localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

  typedef enum logic [CMD_W-1:0] {
    CMD_WRITE_SIZE = 2'd0,
    CMD_SET_CURSOR = 2'd1,
    CMD_TRANSLATE  = 2'd2,
    CMD_DISTANCE   = 2'd3
  } cmd_t;

  // controller to datapath
  typedef struct packed {
    logic latch;
    logic start;
    logic walk;
    logic finish;
  } ctrl_t;

  // datapath to controller
  typedef struct packed {
    cmd_t cmd;
    logic walk_more;
  } status_t;

endpackage

`default_nettype wire

@@ hw/rtl/sow_datapath.sv @@
`default_nettype none

module sow_datapath #(
  parameter int MAX_SEGMENTS = 16,
  parameter int INDEX_WIDTH  = 32
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire sow_pkg::ctrl_t                ctrl,
  output sow_pkg::status_t                   status,
  input  wire logic                          cfg_wr_en,
  input  wire logic [sow_pkg::CFG_W-1:0]     cfg_wr_data,
  input  wire sow_pkg::cmd_t                 cmd_in,
  input  wire logic [sow_pkg::TSEG_W-1:0]    tseg_in,
  input  wire logic [sow_pkg::AMT_W-1:0]     amt_in,
  input  wire logic                          move_in,
  output logic [sow_pkg::SEG_W-1:0]          res_seg,
  output logic [sow_pkg::RIDX_W-1:0]         res_idx,
  output logic [sow_pkg::DIST_W-1:0]         res_dist,
  output logic                               res_oor
);

  localparam int AW    = $clog2(MAX_SEGMENTS);
  localparam int SW    = sow_pkg::SEG_W;
  localparam int PW    = INDEX_WIDTH + 1;
  // lidx plus up to 31 sizes
  localparam int ACC_W = INDEX_WIDTH + 5;
  localparam int CW    = (ACC_W > sow_pkg::DIST_W) ? ACC_W : sow_pkg::DIST_W;
  localparam logic [8:0] MAXV = 9'(MAX_SEGMENTS);

  logic [INDEX_WIDTH-1:0] size_mem [MAX_SEGMENTS];
  logic [MAX_SEGMENTS-1:0] vld;
  logic [INDEX_WIDTH-1:0] rd_data;
  logic                   rd_ok;

  sow_pkg::cmd_t          cmd_r;
  logic [sow_pkg::TSEG_W-1:0] tseg_r;
  logic [INDEX_WIDTH-1:0] amt_r;
  logic                   move_r;
  logic [sow_pkg::CFG_W-1:0] seg_in_use;
  logic [SW-1:0]          cur_seg;
  logic [INDEX_WIDTH-1:0] cur_idx;
  logic [SW-1:0]          seg;
  logic [SW-1:0]          lseg;
  logic [PW-1:0]          pos;
  logic [ACC_W-1:0]       acc;
  logic [INDEX_WIDTH-1:0] eidx;

  logic [SW-1:0]          n;
  logic [INDEX_WIDTH-1:0] size;
  logic                   cur_lt;
  logic [SW-1:0]          start_seg;
  logic [SW:0]            rd_addr;
  logic                   walk_more;
  logic                   fin_oor;
  logic [SW-1:0]          fin_seg;
  logic [INDEX_WIDTH-1:0] fin_idx;
  logic [ACC_W-1:0]       diff;
  logic [CW-1:0]          diff_ext;
  logic                   tseg_ok;

  assign n = ({4'b0, seg_in_use} > MAXV) ? MAXV[SW-1:0] : seg_in_use;
  assign size = rd_ok ? rd_data : '0;
  assign cur_lt = cur_seg < {1'b0, tseg_r};
  assign start_seg = (cmd_r == sow_pkg::CMD_DISTANCE && !cur_lt) ? {1'b0, tseg_r} : cur_seg;
  // during the walk the next entry is always prefetched
  assign rd_addr = ctrl.start ? {1'b0, start_seg} : ({1'b0, seg} + 1'b1);
  assign tseg_ok = {5'b0, tseg_r} < MAXV;

  always_comb begin
    if (cmd_r == sow_pkg::CMD_TRANSLATE) begin
      walk_more = (seg < n) && (pos >= {1'b0, size});
    end else begin
      walk_more = seg < lseg;
    end
  end

  assign status.cmd       = cmd_r;
  assign status.walk_more = walk_more;

  assign fin_oor  = seg >= n;
  assign fin_seg  = fin_oor ? n : seg;
  assign fin_idx  = (fin_oor && pos[PW-1]) ? {INDEX_WIDTH{1'b1}} : pos[INDEX_WIDTH-1:0];
  assign diff     = (acc >= ACC_W'(eidx)) ? (acc - ACC_W'(eidx)) : (ACC_W'(eidx) - acc);
  assign diff_ext = CW'(diff);

  // size table, registered read
  always_ff @(posedge clk) begin
    if (ctrl.finish && cmd_r == sow_pkg::CMD_WRITE_SIZE && tseg_ok) begin
      size_mem[AW'(tseg_r)] <= amt_r;
    end
    rd_data <= size_mem[AW'(rd_addr)];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld        <= '0;
      rd_ok      <= 1'b0;
      seg_in_use <= 5'd1;
      cur_seg    <= '0;
      cur_idx    <= '0;
    end else begin
      rd_ok <= ({3'b0, rd_addr} < MAXV) && vld[AW'(rd_addr)];
      if (cfg_wr_en) begin
        seg_in_use <= cfg_wr_data;
      end
      if (ctrl.finish) begin
        case (cmd_r)
          sow_pkg::CMD_WRITE_SIZE: begin
            if (tseg_ok) begin
              vld[AW'(tseg_r)] <= 1'b1;
            end
          end
          sow_pkg::CMD_SET_CURSOR: begin
            cur_seg <= {1'b0, tseg_r};
            cur_idx <= amt_r;
          end
          sow_pkg::CMD_TRANSLATE: begin
            if (move_r) begin
              cur_seg <= fin_seg;
              cur_idx <= fin_idx;
            end
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.latch) begin
      cmd_r  <= cmd_in;
      tseg_r <= tseg_in;
      amt_r  <= INDEX_WIDTH'(amt_in);
      move_r <= move_in;
    end
    if (ctrl.start) begin
      seg <= start_seg;
      pos <= {1'b0, cur_idx} + {1'b0, amt_r};
      if (cur_lt) begin
        eidx <= cur_idx;
        lseg <= {1'b0, tseg_r};
        acc  <= ACC_W'(amt_r);
      end else begin
        eidx <= amt_r;
        lseg <= cur_seg;
        acc  <= ACC_W'(cur_idx);
      end
    end
    if (ctrl.walk && walk_more) begin
      seg <= seg + 1'b1;
      if (cmd_r == sow_pkg::CMD_TRANSLATE) begin
        pos <= pos - {1'b0, size};
      end else begin
        acc <= acc + ACC_W'(size);
      end
    end
    if (ctrl.finish) begin
      res_seg  <= '0;
      res_idx  <= '0;
      res_dist <= '0;
      res_oor  <= 1'b0;
      case (cmd_r)
        sow_pkg::CMD_TRANSLATE: begin
          res_seg <= fin_seg;
          res_idx <= sow_pkg::RIDX_W'(fin_idx);
          res_oor <= fin_oor;
        end
        sow_pkg::CMD_DISTANCE: begin
          res_dist <= (diff_ext > CW'(sow_pkg::DIST_MAX)) ? sow_pkg::DIST_MAX
                                                          : diff_ext[sow_pkg::DIST_W-1:0];
        end
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/sow_ctrl.sv @@
`default_nettype none

module sow_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              s_tvalid,
  output logic                   s_tready,
  output logic                   m_tvalid,
  input  wire logic              m_tready,
  output sow_pkg::ctrl_t         ctrl,
  input  wire sow_pkg::status_t  status
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_START,
    ST_WALK,
    ST_FINISH
  } state_t;

  state_t state;
  logic   out_free;

  // result register is free or being emptied this cycle
  assign out_free = !m_tvalid || m_tready;

  assign s_tready    = state == ST_IDLE;
  assign ctrl.latch  = (state == ST_IDLE) && s_tvalid;
  assign ctrl.start  = state == ST_START;
  assign ctrl.walk   = state == ST_WALK;
  assign ctrl.finish = (state == ST_FINISH) && out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      m_tvalid <= (m_tvalid && !m_tready) || ctrl.finish;
      case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            state <= ST_START;
          end
        end
        ST_START: begin
          if (status.cmd == sow_pkg::CMD_TRANSLATE || status.cmd == sow_pkg::CMD_DISTANCE) begin
            state <= ST_WALK;
          end else begin
            state <= ST_FINISH;
          end
        end
        ST_WALK: begin
          if (!status.walk_more) begin
            state <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/segmented_offset_walker_top.sv @@
`default_nettype none

// Segmented offset walker: keeps a table of segment sizes and a cursor
// (segment, index), and per input word writes a size, places the cursor,
// translates cursor plus offset into (segment, index), or measures the
// distance from the cursor to a given position. One result word per input
// word. A translate walks over the segments crossed, at most segments_in_use
// of them; a distance walks over the segment gap between the two positions;
// size writes and cursor sets need no walk. The walk reads one table entry
// per cycle through the table's single read port and subtracts or adds it.
// The result sits in an output register, so the next word is taken while
// an earlier result still waits.
module segmented_offset_walker_top #(
  parameter int MAX_SEGMENTS = 16,
  parameter int INDEX_WIDTH  = 32
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_wr_en,
  input  wire logic [sow_pkg::CFG_W-1:0]         cfg_wr_data,   // segments_in_use
  input  wire logic                              s_tvalid,
  output logic                                   s_tready,
  // target_segment[3:0], amount[35:4], move_cursor[36], zero pad
  input  wire logic [sow_pkg::IN_DATA_W-1:0]     s_tdata,
  // cmd[1:0]
  input  wire logic [sow_pkg::CMD_W-1:0]         s_tuser,
  output logic                                   m_tvalid,
  input  wire logic                              m_tready,
  // result_segment[4:0], result_index[36:5], distance[72:37], out_of_range[73], zero pad
  output logic [sow_pkg::OUT_DATA_W-1:0]         m_tdata
);

  sow_pkg::ctrl_t   ctrl;
  sow_pkg::status_t status;

  logic [sow_pkg::SEG_W-1:0]  res_seg;
  logic [sow_pkg::RIDX_W-1:0] res_idx;
  logic [sow_pkg::DIST_W-1:0] res_dist;
  logic                       res_oor;

  sow_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .ctrl     (ctrl),
    .status   (status)
  );

  sow_datapath #(
    .MAX_SEGMENTS (MAX_SEGMENTS),
    .INDEX_WIDTH  (INDEX_WIDTH)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .ctrl        (ctrl),
    .status      (status),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .cmd_in      (sow_pkg::cmd_t'(s_tuser)),
    .tseg_in     (s_tdata[3:0]),
    .amt_in      (s_tdata[35:4]),
    .move_in     (s_tdata[36]),
    .res_seg     (res_seg),
    .res_idx     (res_idx),
    .res_dist    (res_dist),
    .res_oor     (res_oor)
  );

  assign m_tdata = {6'b0, res_oor, res_dist, res_idx, res_seg};

endmodule

`default_nettype wire
